@@ design/timer_table_dispatcher_assert.svh @@
// Assertion macros shared by the timer table dispatcher modules.
// Depends on nothing; included by the modules that check themselves.
`ifndef TIMER_TABLE_DISPATCHER_ASSERT_SVH
`define TIMER_TABLE_DISPATCHER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define TTD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Signal must hold its value on the next edge when the condition is true.
`define TTD_ASSERT_STABLE(label, clk, rst_n, cond, sig, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

@@ design/ttd_pkg.sv @@
// Package for the timer table dispatcher: types, codes and constants.
// Used by ttd_front, ttd_back and timer_table_dispatcher.
package ttd_pkg;

  localparam int unsigned NumSlotsDefault = 16;
  localparam int unsigned IdWidth = 4;
  localparam int unsigned TimeWidth = 32;
  localparam logic [TimeWidth-1:0] TimeMax = '1;

  typedef enum logic [1:0] {
    FuncAdd      = 2'd0,
    FuncDelete   = 2'd1,
    FuncDispatch = 2'd2,
    FuncQuery    = 2'd3
  } func_e;

  typedef struct packed {
    func_e                func;
    logic [IdWidth-1:0]   slot_id;
    logic [TimeWidth-1:0] period;
    logic                 repeat_req;
    logic [TimeWidth-1:0] now;
    logic                 id_ok;
  } cmd_t;

  typedef enum logic [2:0] {
    BackIdle,
    BackScan,
    BackFire,
    BackWait,
    BackOut
  } back_state_e;

  function automatic logic [TimeWidth-1:0] sat_add(logic [TimeWidth-1:0] a,
                                                   logic [TimeWidth-1:0] b);
    logic [TimeWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TimeWidth] ? TimeMax : s[TimeWidth-1:0];
  endfunction

endpackage

@@ design/ttd_front.sv @@
// Front end: accepts transactions, normalizes period, classifies the slot id
// and pushes a command into a two-entry queue. Depends on ttd_pkg.
module ttd_front #(
  parameter int unsigned NumSlots = ttd_pkg::NumSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     func_i,
  input  logic [ttd_pkg::IdWidth-1:0]    slot_id_i,
  input  logic [ttd_pkg::TimeWidth-1:0]  period_i,
  input  logic                           repeat_req_i,
  input  logic [ttd_pkg::TimeWidth-1:0]  now_i,
  output logic                           cmd_valid_o,
  input  logic                           cmd_ready_i,
  output ttd_pkg::cmd_t                  cmd_o
);
  `include "timer_table_dispatcher_assert.svh"

  ttd_pkg::cmd_t mem_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  ttd_pkg::cmd_t cmd_in;
  logic          push, pop;

  always_comb begin
    cmd_in.func       = ttd_pkg::func_e'(func_i);
    cmd_in.slot_id    = slot_id_i;
    cmd_in.period     = (period_i == '0) ? ttd_pkg::TimeWidth'(1) : period_i;
    cmd_in.repeat_req = repeat_req_i;
    cmd_in.now        = now_i;
    cmd_in.id_ok      = (32'(slot_id_i) < 32'(NumSlots));
  end

  assign in_ready    = (cnt_q != 2'd2);
  assign push        = in_valid && in_ready;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= cmd_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end

  `TTD_ASSERT(a_cnt_range, clk_i, rst_ni, cnt_q != 2'd3, "queue count overflow")
  `TTD_ASSERT(a_ptr_cnt, clk_i, rst_ni, (cnt_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "queue pointers disagree with count")
  `TTD_ASSERT(a_full_block, clk_i, rst_ni, (cnt_q == 2'd2) |-> !in_ready, "ready while queue full")
endmodule

@@ design/ttd_back.sv @@
// Back end: holds the slot table and executes commands, scanning the table
// one slot per cycle for dispatch and query. Depends on ttd_pkg.
module ttd_back #(
  parameter int unsigned NumSlots = ttd_pkg::NumSlotsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  ttd_pkg::cmd_t                  cmd_i,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           fired_o,
  output logic [ttd_pkg::IdWidth-1:0]    fired_id_o,
  output logic                           status_o,
  output logic signed [ttd_pkg::TimeWidth-1:0] wait_res_o,
  output logic                           last_o
);
  `include "timer_table_dispatcher_assert.svh"

  localparam int unsigned IdxW = (NumSlots > 1) ? $clog2(NumSlots) : 1;
  localparam int unsigned TW = ttd_pkg::TimeWidth;

  logic [NumSlots-1:0] valid_q, repeat_q, done_q;
  logic [TW-1:0]       expiry_q [NumSlots];
  logic [TW-1:0]       period_q [NumSlots];

  ttd_pkg::back_state_e state_q, state_d;
  ttd_pkg::cmd_t        cmd_q;
  logic [IdxW-1:0]      idx_q;
  logic                 found_q;
  logic                 fin_q;
  logic [IdxW-1:0]      pick_q;
  logic [TW-1:0]        best_q;

  logic                 ov_q;
  logic                 o_fired_q, o_status_q, o_last_q;
  logic [ttd_pkg::IdWidth-1:0] o_id_q;
  logic [TW-1:0]        o_wait_q;

  logic          take, cand, better, scan_end, out_free, dispatch, due_mode;
  logic [TW-1:0] exp_cur, per_cur, diff, wait_val;
  logic [IdxW-1:0] sid;

  assign sid      = IdxW'(cmd_q.slot_id);
  assign out_free = !ov_q || out_ready;
  assign dispatch = (cmd_q.func == ttd_pkg::FuncDispatch);
  // Dispatch looks for due slots first, then rescans all armed slots for the wait.
  assign due_mode = dispatch && !fin_q;
  assign exp_cur  = expiry_q[idx_q];
  assign per_cur  = period_q[pick_q];
  assign cand     = valid_q[idx_q] &&
                    (!due_mode || (!done_q[idx_q] && exp_cur <= cmd_q.now));
  assign better   = cand && (!found_q || exp_cur < best_q);
  assign scan_end = (idx_q == IdxW'(NumSlots - 1));
  assign diff     = best_q - cmd_q.now;
  assign take     = (state_q == ttd_pkg::BackIdle) && cmd_valid_i;
  assign cmd_ready_o = (state_q == ttd_pkg::BackIdle);

  always_comb begin
    if (!found_q)                 wait_val = '1;
    else if (best_q <= cmd_q.now) wait_val = '0;
    else if (diff[TW-1])          wait_val = {1'b0, {(TW-1){1'b1}}};
    else                          wait_val = diff;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ttd_pkg::BackIdle: if (cmd_valid_i) begin
        state_d = (cmd_i.func == ttd_pkg::FuncDispatch || cmd_i.func == ttd_pkg::FuncQuery)
                  ? ttd_pkg::BackScan : ttd_pkg::BackOut;
      end
      ttd_pkg::BackScan: if (scan_end) begin
        if (due_mode) begin
          state_d = (found_q || better) ? ttd_pkg::BackFire : ttd_pkg::BackScan;
        end else begin
          state_d = ttd_pkg::BackWait;
        end
      end
      ttd_pkg::BackFire: if (out_free) state_d = ttd_pkg::BackScan;
      ttd_pkg::BackWait: state_d = ttd_pkg::BackOut;
      ttd_pkg::BackOut:  if (out_free) state_d = ttd_pkg::BackIdle;
      default: state_d = ttd_pkg::BackIdle;
    endcase
  end

  // Table and scan registers.
  always_ff @(posedge clk_i) begin
    if (take) cmd_q <= cmd_i;
    if (state_q == ttd_pkg::BackOut && cmd_q.func == ttd_pkg::FuncAdd && cmd_q.id_ok) begin
      expiry_q[sid] <= ttd_pkg::sat_add(cmd_q.now, cmd_q.period);
      period_q[sid] <= cmd_q.period;
    end
    if (state_q == ttd_pkg::BackFire && out_free && repeat_q[pick_q]) begin
      expiry_q[pick_q] <= ttd_pkg::sat_add(cmd_q.now, per_cur);
    end
    if (state_q == ttd_pkg::BackScan && better) begin
      pick_q <= idx_q;
      best_q <= exp_cur;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ttd_pkg::BackIdle;
      valid_q  <= '0;
      repeat_q <= '0;
      done_q   <= '0;
      idx_q    <= '0;
      found_q  <= 1'b0;
      fin_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (take) begin
        done_q  <= '0;
        idx_q   <= '0;
        found_q <= 1'b0;
        fin_q   <= 1'b0;
      end
      if (state_q == ttd_pkg::BackScan) begin
        if (better) found_q <= 1'b1;
        if (!scan_end) begin
          idx_q <= idx_q + 1'b1;
        end else if (due_mode && !found_q && !better) begin
          // Nothing left to fire: rescan for the wait to the next expiry.
          fin_q <= 1'b1;
          idx_q <= '0;
        end
      end
      if (state_q == ttd_pkg::BackFire && out_free) begin
        done_q[pick_q] <= 1'b1;
        if (!repeat_q[pick_q]) valid_q[pick_q] <= 1'b0;
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      if (state_q == ttd_pkg::BackOut && out_free && cmd_q.id_ok) begin
        case (cmd_q.func)
          ttd_pkg::FuncAdd: begin
            valid_q[sid]  <= 1'b1;
            repeat_q[sid] <= cmd_q.repeat_req;
          end
          ttd_pkg::FuncDelete: begin
            valid_q[sid]  <= 1'b0;
            repeat_q[sid] <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  // Output register, held until out_ready accepts the result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      if (out_ready) ov_q <= 1'b0;
      if (out_free && (state_q == ttd_pkg::BackFire || state_q == ttd_pkg::BackOut)) begin
        ov_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && state_q == ttd_pkg::BackFire) begin
      o_fired_q  <= 1'b1;
      o_id_q     <= ttd_pkg::IdWidth'(pick_q);
      o_status_q <= 1'b0;
      o_last_q   <= 1'b0;
    end else if (out_free && state_q == ttd_pkg::BackOut) begin
      o_fired_q  <= 1'b0;
      o_id_q     <= '0;
      o_status_q <= (cmd_q.func == ttd_pkg::FuncDelete) && !(cmd_q.id_ok && valid_q[sid]);
      o_last_q   <= 1'b1;
      if (cmd_q.func == ttd_pkg::FuncAdd || cmd_q.func == ttd_pkg::FuncDelete) o_wait_q <= '0;
      else o_wait_q <= wait_val;
    end
  end

  assign out_valid  = ov_q;
  assign fired_o    = o_fired_q;
  assign fired_id_o = o_id_q;
  assign status_o   = o_status_q;
  assign wait_res_o = o_fired_q ? '0 : o_wait_q;
  assign last_o     = o_last_q;

  `TTD_ASSERT(a_fire_found, clk_i, rst_ni, (state_q == ttd_pkg::BackFire) |-> found_q && valid_q[pick_q], "fire without a valid pick")
  `TTD_ASSERT(a_fired_not_last, clk_i, rst_ni, ov_q |-> !(o_fired_q && o_last_q), "fired result marked last")
  `TTD_ASSERT_STABLE(a_out_hold, clk_i, rst_ni, ov_q && !out_ready, o_id_q, "result changed while stalled")
endmodule

@@ design/timer_table_dispatcher.sv @@
// Timer table dispatcher top level: front queue plus table back end.
// Add/delete give one result each; query gives one after scanning the table one slot per cycle.
// Dispatch gives one result per fired timer and then a last result; output stalls hold it back.
// One command is worked at a time; the front queue holds two more.
// rst_ni asynchronously clears all valid and repeat marks and empties the queue.
module timer_table_dispatcher #(
  parameter int unsigned NumSlots = ttd_pkg::NumSlotsDefault
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    func_i,
  input  logic [ttd_pkg::IdWidth-1:0]   slot_id_i,
  input  logic [ttd_pkg::TimeWidth-1:0] period_i,
  input  logic                          repeat_req_i,
  input  logic [ttd_pkg::TimeWidth-1:0] now_i,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          fired_o,
  output logic [ttd_pkg::IdWidth-1:0]   fired_id_o,
  output logic                          status_o,
  output logic signed [ttd_pkg::TimeWidth-1:0] wait_res_o,
  output logic                          last_o
);
  logic          cmd_valid, cmd_ready;
  ttd_pkg::cmd_t cmd;

  ttd_front #(.NumSlots(NumSlots)) u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .func_i, .slot_id_i, .period_i,
    .repeat_req_i, .now_i, .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready),
    .cmd_o(cmd)
  );

  ttd_back #(.NumSlots(NumSlots)) u_back (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready),
    .cmd_i(cmd), .out_valid, .out_ready, .fired_o, .fired_id_o, .status_o,
    .wait_res_o, .last_o
  );
endmodule

@@ bench/timer_table_dispatcher_tb.sv @@
// Testbench for timer_table_dispatcher: random and directed timer commands
// checked against a behavioral timer table. Depends on ttd_pkg and the RTL.
module timer_table_dispatcher_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSLOT = 16;

  typedef struct packed {
    ttd_pkg::func_e func;
    logic [3:0]  slot_id;
    logic [31:0] period;
    logic        repeat_req;
    logic [31:0] now;
  } timer_cmd_t;

  typedef struct packed {
    logic        fired;
    logic [3:0]  fired_id;
    logic        status;
    logic [31:0] wait_res;
    logic        last;
  } timer_rsp_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] func_i = '0;
  logic [3:0] slot_id_i = '0;
  logic [31:0] period_i = '0;
  logic repeat_req_i = 1'b0;
  logic [31:0] now_i = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic fired_o;
  logic [3:0] fired_id_o;
  logic status_o;
  logic signed [31:0] wait_res_o;
  logic last_o;

  timer_table_dispatcher dut (.*);

  timer_cmd_t pending_cmds[$];
  timer_rsp_t expected_rsps[$];
  int errors = 0;
  int n_sent = 0;
  int n_fired = 0;
  int n_rsp = 0;
  bit quiet = 1'b0;

  // Shadow timer table
  bit          tbl_valid[NSLOT];
  bit          tbl_repeat[NSLOT];
  logic [31:0] tbl_expiry[NSLOT];
  logic [31:0] tbl_period[NSLOT];

  function automatic logic [31:0] time_sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] wait_to_next(logic [31:0] now);
    bit any;
    logic [31:0] best;
    any = 0;
    best = '0;
    for (int i = 0; i < NSLOT; i++)
      if (tbl_valid[i] && (!any || tbl_expiry[i] < best)) begin
        best = tbl_expiry[i];
        any = 1;
      end
    if (!any) return 32'hFFFF_FFFF;
    if (best <= now) return '0;
    if (best - now > 32'h7FFF_FFFF) return 32'h7FFF_FFFF;
    return best - now;
  endfunction

  function automatic void push_rsp(bit f, logic [3:0] id, bit st, logic [31:0] w, bit l);
    timer_rsp_t r;
    r.fired = f;
    r.fired_id = id;
    r.status = st;
    r.wait_res = w;
    r.last = l;
    expected_rsps.push_back(r);
  endfunction

  function automatic void predict_timer(timer_cmd_t c);
    bit done[NSLOT];
    logic [31:0] p;
    bit found;
    int pick;
    case (c.func)
      ttd_pkg::FuncAdd: begin
        p = (c.period == 0) ? 32'd1 : c.period;
        tbl_valid[c.slot_id] = 1;
        tbl_repeat[c.slot_id] = c.repeat_req;
        tbl_period[c.slot_id] = p;
        tbl_expiry[c.slot_id] = time_sat_add(c.now, p);
        push_rsp(0, 0, 0, 0, 1);
      end
      ttd_pkg::FuncDelete: begin
        if (tbl_valid[c.slot_id]) begin
          tbl_valid[c.slot_id] = 0;
          tbl_repeat[c.slot_id] = 0;
          push_rsp(0, 0, 0, 0, 1);
        end else begin
          push_rsp(0, 0, 1, 0, 1);
        end
      end
      ttd_pkg::FuncQuery: push_rsp(0, 0, 0, wait_to_next(c.now), 1);
      default: begin
        for (int i = 0; i < NSLOT; i++) done[i] = 0;
        forever begin
          found = 0;
          pick = 0;
          for (int i = 0; i < NSLOT; i++)
            if (tbl_valid[i] && !done[i] && tbl_expiry[i] <= c.now &&
                (!found || tbl_expiry[i] < tbl_expiry[pick])) begin
              pick = i;
              found = 1;
            end
          if (!found) break;
          done[pick] = 1;
          if (tbl_repeat[pick]) tbl_expiry[pick] = time_sat_add(c.now, tbl_period[pick]);
          else tbl_valid[pick] = 0;
          push_rsp(1, pick[3:0], 0, 0, 0);
        end
        push_rsp(0, 0, 0, wait_to_next(c.now), 1);
      end
    endcase
  endfunction

  function automatic void queue_cmd(ttd_pkg::func_e f, int id, logic [31:0] p, bit r,
                                    logic [31:0] now);
    timer_cmd_t c;
    c.func = f;
    c.slot_id = id[3:0];
    c.period = p;
    c.repeat_req = r;
    c.now = now;
    pending_cmds.push_back(c);
  endfunction

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #4_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Driver: hold the transaction until accepted
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!in_valid || in_ready) begin
        if (pending_cmds.size() > 0 && (quiet || $urandom_range(99) >= 24)) begin
          timer_cmd_t c;
          c = pending_cmds.pop_front();
          predict_timer(c);
          func_i <= c.func;
          slot_id_i <= c.slot_id;
          period_i <= c.period;
          repeat_req_i <= c.repeat_req;
          now_i <= c.now;
          in_valid <= 1'b1;
          n_sent++;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_ready <= quiet || ($urandom_range(99) >= 24);
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) begin
      timer_rsp_t e;
      n_rsp++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result fired=%0d id=%0d", fired_o, fired_id_o);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (fired_o) n_fired++;
        if (fired_o !== e.fired) begin
          $error("fired: expected %0d actual %0d", e.fired, fired_o); errors++;
        end
        if (fired_id_o !== e.fired_id) begin
          $error("fired_id: expected %0d actual %0d", e.fired_id, fired_id_o); errors++;
        end
        if (status_o !== e.status) begin
          $error("status: expected %0d actual %0d", e.status, status_o); errors++;
        end
        if (wait_res_o !== e.wait_res) begin
          $error("wait_res: expected %0d actual %0d", $signed(e.wait_res), wait_res_o);
          errors++;
        end
        if (last_o !== e.last) begin
          $error("last: expected %0d actual %0d", e.last, last_o); errors++;
        end
      end
    end
  end

  initial begin
    logic [31:0] t;
    int dur;
    for (int i = 0; i < NSLOT; i++) begin
      tbl_valid[i] = 0;
      tbl_repeat[i] = 0;
      tbl_expiry[i] = '0;
      tbl_period[i] = '0;
    end
    // Directed: empty table, period 0, saturation, ties, refire guard, rearm
    queue_cmd(ttd_pkg::FuncQuery, 0, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncDispatch, 0, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(ttd_pkg::FuncDelete, 15, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncAdd, 0, 0, 1, 100);
    queue_cmd(ttd_pkg::FuncAdd, 15, 32'hFFFF_FFFF, 1, 32'hFFFF_FFF0);
    queue_cmd(ttd_pkg::FuncAdd, 3, 5, 0, 95);
    queue_cmd(ttd_pkg::FuncAdd, 7, 5, 0, 95);
    queue_cmd(ttd_pkg::FuncAdd, 3, 6, 1, 95);
    queue_cmd(ttd_pkg::FuncQuery, 0, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncQuery, 0, 0, 0, 200);
    queue_cmd(ttd_pkg::FuncDispatch, 0, 0, 0, 101);
    queue_cmd(ttd_pkg::FuncDispatch, 0, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(ttd_pkg::FuncDispatch, 0, 0, 0, 32'hFFFF_FFFF);
    queue_cmd(ttd_pkg::FuncAdd, 9, 32'h8000_0000, 0, 0);
    queue_cmd(ttd_pkg::FuncQuery, 0, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncDelete, 9, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncDelete, 9, 0, 0, 0);
    for (int i = 0; i < NSLOT; i++) queue_cmd(ttd_pkg::FuncDelete, i, 0, 0, 0);
    queue_cmd(ttd_pkg::FuncQuery, 0, 0, 0, 32'hFFFF_FFFF);
    // Random: advancing time, mostly small periods so dispatches fire
    t = $urandom;
    for (int k = 0; k < 326; k++) begin
      int sel;
      logic [31:0] p;
      bit r;
      sel = $urandom_range(99);
      p = ($urandom_range(9) == 0) ? $urandom : $urandom_range(40);
      r = 1'($urandom_range(1));
      if ($urandom_range(19) == 0) t = $urandom;
      else t = time_sat_add(t, $urandom_range(15));
      if (sel < 40) queue_cmd(ttd_pkg::FuncAdd, $urandom_range(15), p, r, t);
      else if (sel < 55) queue_cmd(ttd_pkg::FuncDelete, $urandom_range(15), $urandom, r, t);
      else if (sel < 85) queue_cmd(ttd_pkg::FuncDispatch, $urandom_range(15), $urandom, r, t);
      else queue_cmd(ttd_pkg::FuncQuery, $urandom_range(15), $urandom, r, t);
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Quiet stretch with no idling for part of the run
    wait (n_sent >= 150);
    quiet = 1'b1;
    wait (n_sent >= 230);
    quiet = 1'b0;
    wait (pending_cmds.size() == 0);
    @(posedge clk_i);
    while (in_valid && !in_ready) @(posedge clk_i);
    while (expected_rsps.size() > 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    $display("Ran %0d timer commands, %0d results, %0d timers fired.", n_sent, n_rsp,
             n_fired);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule
